// ===== rtl/core/slifr_pkg.sv =====
// Shared types and codes for the sorted list insert/find/remove block.
`timescale 1ns / 1ps

package slifr_pkg;

    // Widths of the item fields
    localparam int unsigned ActionW = 2;
    localparam int unsigned ValueW  = 32;
    localparam int unsigned StatusW = 2;
    localparam int unsigned PosW    = 4;
    localparam int unsigned CountW  = 5;

    // Action codes
    localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
    localparam logic [ActionW-1:0] ACT_FIND   = 2'd1;
    localparam logic [ActionW-1:0] ACT_REMOVE = 2'd2;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
    localparam logic [StatusW-1:0] ST_MISSING = 2'd2;

    typedef logic signed [ValueW-1:0] t_value;

    // Command broadcast to every cell
    typedef struct packed {
        logic   shift_in;   // insert: make room at the boundary, load key there
        logic   shift_out;  // remove: close the gap from the boundary up
        t_value key;
    } t_cmd;

    // Per-cell compare flags
    typedef struct packed {
        logic lt;   // occupied and entry < key
        logic hit;  // first occupied entry equal to key
    } t_flags;

endpackage

// ===== rtl/core/slifr_cell.sv =====
// One cell of the sorted chain: holds one entry, compares it and shifts.
`timescale 1ns / 1ps

module slifr_cell (
    input  logic              i_clk,
    input  logic              i_occ,        // cell lies below the count
    input  slifr_pkg::t_cmd   i_cmd,
    input  logic              i_left_lt,    // lt of lower neighbor, 1 for cell 0
    input  slifr_pkg::t_value i_left_entry,
    input  slifr_pkg::t_value i_right_entry,
    output slifr_pkg::t_value o_entry,
    output slifr_pkg::t_value o_next,
    output slifr_pkg::t_flags o_flags
);

    slifr_pkg::t_value r_entry;
    slifr_pkg::t_value n_entry;
    logic              w_lt;
    logic              w_bound;

    // Compare against the key; entries below the boundary are smaller
    assign w_lt    = i_occ && (r_entry < i_cmd.key);
    assign w_bound = !w_lt && i_left_lt;

    assign o_flags.lt  = w_lt;
    assign o_flags.hit = i_occ && w_bound && (r_entry == i_cmd.key);

    // Shift right on insert, left on remove, from the boundary up
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift_in && !w_lt) begin
            n_entry = w_bound ? i_cmd.key : i_left_entry;
        end else if (i_cmd.shift_out && !w_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// ===== rtl/core/sorted_list_insert_find_remove.sv =====
// Top level: sorted store of signed values as a chain of compare/shift cells.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is taken; the whole chain compares against the key in
// parallel and shifts in the same cycle, so no item waits on another.
// An item is accepted whenever the output register is empty or being taken.
// Reset (synchronous, active low) empties the store; entries are not cleared.
`timescale 1ns / 1ps

module sorted_list_insert_find_remove #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [1:0] action, [33:2] value, rest zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [1:0] status, [5:2] position,
                                     // [10:6] entry_count, [42:11] smallest
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    logic [slifr_pkg::ActionW-1:0] w_action;
    slifr_pkg::t_value             w_key;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_found;
    logic [IW-1:0]                 w_pos;
    slifr_pkg::t_cmd               w_cmd;

    slifr_pkg::t_value w_entry [CAPACITY];
    slifr_pkg::t_value w_next  [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_hit;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;

    logic [slifr_pkg::StatusW-1:0] r_status,   n_status;
    logic [slifr_pkg::PosW-1:0]    r_position, n_position;
    logic [slifr_pkg::CountW-1:0]  r_ecount;
    slifr_pkg::t_value             r_smallest, n_smallest;

    assign w_action = i_s_tdata[1:0];
    assign w_key    = i_s_tdata[33:2];

    // Handshake: output register parts the two sides
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count >= CapCount);

    // Command to the chain
    assign w_cmd.key       = w_key;
    assign w_cmd.shift_in  = w_accept && (w_action == slifr_pkg::ACT_INSERT) && !w_full;
    assign w_cmd.shift_out = w_accept && (w_action == slifr_pkg::ACT_REMOVE) && w_found;

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        slifr_pkg::t_flags w_flags;

        slifr_cell u_cell (
            .i_clk         (i_clk),
            .i_occ         (IW'(g) < r_count[IW-1:0] || r_count == CapCount),
            .i_cmd         (w_cmd),
            .i_left_lt     ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_left_entry  ((g == 0) ? w_key : w_entry[(g == 0) ? 0 : g - 1]),
            .i_right_entry ((g == CAPACITY - 1) ? w_entry[g]
                                                : w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry       (w_entry[g]),
            .o_next        (w_next[g]),
            .o_flags       (w_flags)
        );

        assign w_lt[g]  = w_flags.lt;
        assign w_hit[g] = w_flags.hit;
    end

    // Found flag and position of the one-hot hit
    always_comb begin
        w_pos = '0;
        for (int unsigned k = 0; k < CAPACITY; k++) begin
            if (w_hit[k]) begin
                w_pos = w_pos | IW'(k);
            end
        end
    end
    assign w_found = |w_hit;

    // Count update
    always_comb begin
        n_count = r_count;
        if (w_cmd.shift_in) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.shift_out) begin
            n_count = r_count - CW'(1);
        end
    end

    // Result fields
    always_comb begin
        n_status   = slifr_pkg::ST_OK;
        n_position = '0;
        case (w_action) inside
            slifr_pkg::ACT_INSERT: begin
                if (w_full) begin
                    n_status = slifr_pkg::ST_FULL;
                end
            end
            slifr_pkg::ACT_FIND, slifr_pkg::ACT_REMOVE: begin
                if (w_found) begin
                    n_position = slifr_pkg::PosW'(w_pos);
                end else begin
                    n_status = slifr_pkg::ST_MISSING;
                end
            end
            default: begin
                n_status = slifr_pkg::ST_OK;
            end
        endcase
        n_smallest = (n_count != '0) ? w_next[0] : '0;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_position <= n_position;
            r_ecount   <= slifr_pkg::CountW'(n_count);
            r_smallest <= n_smallest;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_smallest, r_ecount, r_position, r_status};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("count above capacity");

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one first-match cell");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == slifr_pkg::ACT_INSERT && w_full) |=> $stable(r_count))
        else $error("dropped insert changed the count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == slifr_pkg::ST_FULL)
            |-> (r_ecount == slifr_pkg::CountW'(CAPACITY)))
        else $error("full status without a full count");

    a_shift_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.shift_in && w_cmd.shift_out))
        else $error("insert and remove shift together");

endmodule
